>>> src/lpfd_pkg.sv
package lpfd_pkg;

    // session phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CLOSED  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // header bytes before the last one
    localparam logic [1:0] HDR_LAST_IDX = 2'd3;

    localparam logic [15:0] MAX_FIELD_RESET = 16'd1024;

    // one received byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_beat;

    // one result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [15:0] id;
        logic        last;
    } t_result;

endpackage

>>> src/length_prefixed_frame_deframer_unit.sv
// a byte passes through the input register and then the result register on its way to a result beat
// throughput: one byte per cycle while i_stall is low, set by the combinational parser between
// the input register and the result register
// reset (synchronous, active low): header phase, counters cleared,
// limit back to 1024; a closed session only reopens through reset
module length_prefixed_frame_deframer_unit
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // limit register
    input  logic        i_max_field_value_we,
    input  logic [15:0] i_max_field_value,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_message_id,
    output logic        o_last_byte
);

    logic [15:0] r_limit;
    t_in_beat    w_beat;
    logic        w_advance;
    t_result     w_result;

    // user must change limit only while idle (unenforced); no shadowing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= MAX_FIELD_RESET;
        end else if (i_max_field_value_we) begin
            r_limit <= i_max_field_value;
        end
    end

    // input register, stalls only when the result register is blocked
    lpfd_input_stage u_input_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_advance   (w_advance),
        .o_beat      (w_beat),
        .o_stall     (o_stall)
    );

    // header collection, limit check, payload counting and result register
    lpfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (r_limit),
        .i_beat    (w_beat),
        .i_stall   (i_stall),
        .o_advance (w_advance),
        .o_valid   (o_valid),
        .o_result  (w_result)
    );

    assign o_result_kind  = w_result.kind;
    assign o_payload_byte = w_result.payload;
    assign o_message_id   = w_result.id;
    assign o_last_byte    = w_result.last;

endmodule

>>> src/lpfd_in_reg.sv
module lpfd_in_reg
    import lpfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_data_byte,
    input  logic       i_clear,
    output t_in_beat   o_beat
);

    logic       r_valid;
    logic [7:0] r_data;

    // a load wins over a clear in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data_byte;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

>>> src/lpfd_input_stage.sv
module lpfd_input_stage
    import lpfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_advance,
    output t_in_beat   o_beat,
    output logic       o_stall
);

    logic w_take;

    // register frees up when the parser consumes its beat
    assign o_stall = o_beat.valid && !i_advance;
    assign w_take  = i_valid && !o_stall;

    lpfd_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_take),
        .i_data_byte (i_data_byte),
        .i_clear     (i_advance),
        .o_beat      (o_beat)
    );

endmodule

>>> src/lpfd_parser.sv
module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_limit,
    input  t_in_beat    i_beat,
    input  logic        i_stall,
    output logic        o_advance,
    output logic        o_valid,
    output t_result     o_result
);

    logic [1:0]  r_phase;
    logic [1:0]  r_hdr_cnt;
    logic [23:0] r_hdr_bytes;
    logic [15:0] r_cur_id;
    logic [15:0] r_remaining;
    logic        r_out_valid;
    t_result     r_out;

    logic [1:0]  n_phase;
    logic [1:0]  n_hdr_cnt;
    logic [23:0] n_hdr_bytes;
    logic [15:0] n_cur_id;
    logic [15:0] n_remaining;
    logic        w_emit;
    t_result     w_res;

    logic        w_out_ready;
    logic        w_fire;
    logic [15:0] w_id;
    logic [15:0] w_len;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign o_advance   = w_out_ready;
    assign w_fire      = i_beat.valid && w_out_ready;

    assign w_id  = r_hdr_bytes[23:8];
    assign w_len = {r_hdr_bytes[7:0], i_beat.data};

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr_bytes = r_hdr_bytes;
        n_cur_id    = r_cur_id;
        n_remaining = r_remaining;
        w_emit      = 1'b0;
        w_res       = '0;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt != HDR_LAST_IDX) begin
                    n_hdr_bytes = {r_hdr_bytes[15:0], i_beat.data};
                    n_hdr_cnt   = r_hdr_cnt + 2'd1;
                end else begin
                    n_cur_id    = w_id;
                    n_hdr_cnt   = '0;
                    n_hdr_bytes = '0;
                    w_emit      = 1'b1;
                    w_res.id    = w_id;
                    if ((w_id > i_limit) || (w_len > i_limit)) begin
                        n_phase     = PH_CLOSED;
                        n_remaining = '0;
                        w_res.kind  = KIND_ERROR;
                    end else if (w_len == 16'd0) begin
                        n_remaining = '0;
                        w_res.kind  = KIND_EMPTY;
                    end else begin
                        n_phase     = PH_PAYLOAD;
                        n_remaining = w_len;
                        w_emit      = 1'b0;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_remaining   = r_remaining - 16'd1;
                w_emit        = 1'b1;
                w_res.kind    = KIND_DATA;
                w_res.payload = i_beat.data;
                w_res.id      = r_cur_id;
                w_res.last    = (r_remaining == 16'd1);
                if (r_remaining == 16'd1) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                // closed, and the unused code, swallow everything
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_hdr_bytes <= '0;
            r_cur_id    <= '0;
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_hdr_bytes <= n_hdr_bytes;
                r_cur_id    <= n_cur_id;
                r_remaining <= n_remaining;
            end
            if (w_out_ready) begin
                r_out_valid <= w_fire && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
